@@ design/thpl_pkg.sv @@
// Shared types, constants and segment tables for the thermistor temperature block.
// Used by every module of the block; depends on nothing else.
package thpl_pkg;

   localparam int BRK_COUNT           = 16;
   localparam int BRK_W               = 12;
   localparam int MV_W                = 12;
   localparam int TEMP_W              = 8;
   localparam int RAW_W               = 16;
   localparam int STEP_W              = 4;
   localparam int QUOT_W              = 4;
   localparam int PROD_W              = BRK_W + STEP_W;
   localparam int SEG_W               = 4;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 48;
   localparam int BRK_PER_CSR         = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [MV_W-1:0]          MV_LOW_LIMIT  = 12'd80;
   localparam logic signed [TEMP_W-1:0] TEMP_DISABLED = 8'sd30;
   localparam logic signed [TEMP_W-1:0] TEMP_HOT      = 8'sd80;
   localparam logic signed [TEMP_W-1:0] TEMP_COLD     = -8'sd25;
   localparam logic [15:0]              RECIP_FIVE    = 16'd52429;
   localparam int                       RECIP_SHIFT   = 18;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEMP_ENABLE = 3'd0,
      CSR_BRK_1_4     = 3'd1,
      CSR_BRK_5_8     = 3'd2,
      CSR_BRK_9_12    = 3'd3,
      CSR_BRK_13_16   = 3'd4
   } csr_index_type;

   // Entry 0 holds breakpoint 1, entry 15 holds breakpoint 16.
   typedef logic [BRK_COUNT-1:0][BRK_W-1:0] brk_array_type;

   typedef struct packed {
      logic [MV_W-1:0]          mv;
      logic [BRK_W-1:0]         num;
      logic [BRK_W-1:0]         den;
      logic [STEP_W-1:0]        step;
      logic signed [TEMP_W-1:0] base;
      logic                     fixed;
   } entry_type;

   typedef struct packed {
      logic [MV_W-1:0]          mv;
      logic [BRK_W-1:0]         den;
      logic signed [TEMP_W-1:0] base;
      logic                     fixed;
      logic [PROD_W-1:0]        rem;
   } mul_stage_type;

   typedef struct packed {
      logic [MV_W-1:0]          mv;
      logic [BRK_W-1:0]         den;
      logic signed [TEMP_W-1:0] base;
      logic                     fixed;
      logic [PROD_W-1:0]        rem;
      logic [1:0]               quot_hi;
   } div_stage_type;

   function automatic logic signed [TEMP_W-1:0] seg_base(input logic [SEG_W-1:0] k);
      logic signed [TEMP_W-1:0] b;
      case (k)
         4'd1:    b = -8'sd25;
         4'd2:    b = -8'sd15;
         4'd3:    b = -8'sd10;
         4'd4:    b = -8'sd5;
         4'd5:    b = 8'sd0;
         4'd6:    b = 8'sd5;
         4'd7:    b = 8'sd10;
         4'd8:    b = 8'sd20;
         4'd9:    b = 8'sd30;
         4'd10:   b = 8'sd40;
         4'd11:   b = 8'sd45;
         4'd12:   b = 8'sd50;
         4'd13:   b = 8'sd55;
         4'd14:   b = 8'sd60;
         4'd15:   b = 8'sd70;
         default: b = 8'sd0;
      endcase
      return b;
   endfunction

   function automatic logic [STEP_W-1:0] seg_step(input logic [SEG_W-1:0] k);
      logic [STEP_W-1:0] s;
      case (k)
         4'd1, 4'd7, 4'd8, 4'd9, 4'd14, 4'd15: s = 4'd10;
         4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
         4'd10, 4'd11, 4'd12, 4'd13:           s = 4'd5;
         default:                              s = 4'd0;
      endcase
      return s;
   endfunction

endpackage

@@ design/thermistor_piecewise_linear_temp.sv @@
// Thermistor reading to temperature through a sixteen-point piecewise-linear table.
// A reading is registered in the front end, stored in the queue and then registered in the
// back end's multiply, divide and result registers. Throughput is one reading per cycle while
// the queue has room; a four-entry queue (the default depth) decouples the front and back ends.
// Synchronous reset clears the enable, all breakpoints and every valid flag.
// Uses thpl_pkg, thpl_front, thpl_queue and thpl_back.
module thermistor_piecewise_linear_temp #(
   parameter int QUEUE_DEPTH = thpl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [thpl_pkg::RAW_W-1:0]          req_raw_ts_reading,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [thpl_pkg::MV_W-1:0]           rsp_ts_millivolts,
   output logic signed [thpl_pkg::TEMP_W-1:0]  rsp_temperature_c,
   input  logic                                csr_write_enable,
   input  logic [thpl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [thpl_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   logic                     temp_enable_ff;
   thpl_pkg::brk_array_type  brk_ff;
   logic                     push_valid;
   logic                     push_full;
   thpl_pkg::entry_type      push_entry;
   logic                     pop_valid;
   logic                     pop_ready;
   thpl_pkg::entry_type      pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_enable_ff <= 1'b0;
         brk_ff         <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            thpl_pkg::CSR_TEMP_ENABLE: begin
               temp_enable_ff <= csr_write_data[0];
            end
            thpl_pkg::CSR_BRK_1_4: begin
               for (int j = 0; j < thpl_pkg::BRK_PER_CSR; j++) begin
                  brk_ff[j] <= csr_write_data[thpl_pkg::BRK_W*j +: thpl_pkg::BRK_W];
               end
            end
            thpl_pkg::CSR_BRK_5_8: begin
               for (int j = 0; j < thpl_pkg::BRK_PER_CSR; j++) begin
                  brk_ff[4+j] <= csr_write_data[thpl_pkg::BRK_W*j +: thpl_pkg::BRK_W];
               end
            end
            thpl_pkg::CSR_BRK_9_12: begin
               for (int j = 0; j < thpl_pkg::BRK_PER_CSR; j++) begin
                  brk_ff[8+j] <= csr_write_data[thpl_pkg::BRK_W*j +: thpl_pkg::BRK_W];
               end
            end
            thpl_pkg::CSR_BRK_13_16: begin
               for (int j = 0; j < thpl_pkg::BRK_PER_CSR; j++) begin
                  brk_ff[12+j] <= csr_write_data[thpl_pkg::BRK_W*j +: thpl_pkg::BRK_W];
               end
            end
            default: begin
            end
         endcase
      end
   end

   thpl_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_ts_reading (req_raw_ts_reading),
      .temp_enable        (temp_enable_ff),
      .brk                (brk_ff),
      .push_valid         (push_valid),
      .push_full          (push_full),
      .push_entry         (push_entry)
   );

   thpl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   thpl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ts_millivolts (rsp_ts_millivolts),
      .rsp_temperature_c (rsp_temperature_c)
   );

`ifndef SYNTHESIS
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temperature_c >= thpl_pkg::TEMP_COLD &&
                     rsp_temperature_c <= thpl_pkg::TEMP_HOT))
      else $error("Temperature outside the table range.");

   a_mv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ts_millivolts <= 12'd3276)
      else $error("Millivolt result above the largest possible conversion.");

   a_low_voltage: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ts_millivolts < thpl_pkg::MV_LOW_LIMIT)
         |-> rsp_temperature_c == thpl_pkg::TEMP_DISABLED)
      else $error("Low voltage reading did not give the fallback temperature.");
`endif

endmodule

@@ design/thpl_front.sv @@
// Front end: accepts raw readings, converts them to millivolts and picks the segment.
// Uses thpl_pkg; feeds thpl_queue.
module thpl_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [thpl_pkg::RAW_W-1:0]    req_raw_ts_reading,
   input  logic                          temp_enable,
   input  thpl_pkg::brk_array_type       brk,
   output logic                          push_valid,
   input  logic                          push_full,
   output thpl_pkg::entry_type           push_entry
);

   logic                         conv_valid_ff;
   logic                         conv_valid_in;
   logic [thpl_pkg::MV_W-1:0]    conv_mv_ff;
   logic [thpl_pkg::MV_W-1:0]    conv_mv_in;
   logic                         conv_load;
   logic [11:0]                  code;
   logic [13:0]                  code_x4;
   logic [29:0]                  mv_prod;
   logic [thpl_pkg::SEG_W-1:0]   seg;
   logic                         seg_found;

   assign req_stall  = conv_valid_ff && push_full;
   assign conv_load  = !conv_valid_ff || !push_full;
   assign push_valid = conv_valid_ff;

   // Millivolts are code*4/5, the division done by a reciprocal multiply.
   assign code       = {req_raw_ts_reading[15:8], req_raw_ts_reading[3:0]};
   assign code_x4    = {code, 2'b00};
   assign mv_prod    = {16'd0, code_x4} * {14'd0, thpl_pkg::RECIP_FIVE};
   assign conv_mv_in = mv_prod[29:thpl_pkg::RECIP_SHIFT];
   assign conv_valid_in = conv_load ? req_valid : conv_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_valid_ff <= 1'b0;
      end else begin
         conv_valid_ff <= conv_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (conv_load && req_valid) begin
         conv_mv_ff <= conv_mv_in;
      end
   end

   always_comb begin
      seg       = '0;
      seg_found = 1'b0;
      for (int k = 1; k < thpl_pkg::BRK_COUNT; k++) begin
         if (conv_mv_ff <= brk[k-1]) begin
            seg       = thpl_pkg::SEG_W'(k);
            seg_found = 1'b1;
         end
      end
   end

   always_comb begin
      push_entry.mv    = conv_mv_ff;
      push_entry.num   = brk[seg - 4'd1] - conv_mv_ff;
      push_entry.den   = brk[seg - 4'd1] - brk[seg];
      push_entry.step  = thpl_pkg::seg_step(seg);
      push_entry.base  = thpl_pkg::seg_base(seg);
      push_entry.fixed = 1'b0;
      if (conv_mv_ff < thpl_pkg::MV_LOW_LIMIT || !temp_enable) begin
         push_entry.base  = thpl_pkg::TEMP_DISABLED;
         push_entry.fixed = 1'b1;
      end else if (conv_mv_ff < brk[thpl_pkg::BRK_COUNT-1]) begin
         push_entry.base  = thpl_pkg::TEMP_HOT;
         push_entry.fixed = 1'b1;
      end else if (!seg_found) begin
         push_entry.base  = thpl_pkg::TEMP_COLD;
         push_entry.fixed = 1'b1;
      end else if (push_entry.den == '0) begin
         push_entry.fixed = 1'b1;
      end
   end

endmodule

@@ design/thpl_queue.sv @@
// Short queue of classified readings between the front end and the back end.
// Uses thpl_pkg for the entry type.
module thpl_queue #(
   parameter int DEPTH = thpl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_full,
   input  thpl_pkg::entry_type  push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output thpl_pkg::entry_type  pop_entry
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   thpl_pkg::entry_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff;
   logic [PTR_W-1:0]        wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [PTR_W-1:0]        rd_ptr_in;
   logic [COUNT_W-1:0]      count_ff;
   logic [COUNT_W-1:0]      count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_full = (count_ff == COUNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ design/thpl_back.sv @@
// Back end: scales the segment offset, divides it over two stages and adds the base.
// Uses thpl_pkg; drains thpl_queue and drives the result channel.
module thpl_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  thpl_pkg::entry_type                 pop_entry,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [thpl_pkg::MV_W-1:0]           rsp_ts_millivolts,
   output logic signed [thpl_pkg::TEMP_W-1:0]  rsp_temperature_c
);

   localparam int PW = thpl_pkg::PROD_W;

   logic                                advance;
   logic                                mul_valid_ff;
   thpl_pkg::mul_stage_type             mul_ff;
   thpl_pkg::mul_stage_type             mul_in;
   logic                                div_valid_ff;
   thpl_pkg::div_stage_type             div_ff;
   thpl_pkg::div_stage_type             div_in;
   logic                                rsp_valid_ff;
   logic [thpl_pkg::MV_W-1:0]           rsp_mv_ff;
   logic signed [thpl_pkg::TEMP_W-1:0]  rsp_temp_ff;
   logic signed [thpl_pkg::TEMP_W-1:0]  rsp_temp_in;
   logic [PW-1:0]                       den_a;
   logic [PW-1:0]                       rem_a;
   logic [PW-1:0]                       den_b;
   logic [PW-1:0]                       rem_b;
   logic [1:0]                          quot_lo;
   logic [thpl_pkg::QUOT_W-1:0]         quot;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign pop_ready = advance;

   always_comb begin
      mul_in.mv    = pop_entry.mv;
      mul_in.den   = pop_entry.den;
      mul_in.base  = pop_entry.base;
      mul_in.fixed = pop_entry.fixed;
      mul_in.rem   = {{thpl_pkg::STEP_W{1'b0}}, pop_entry.num}
                     * {{thpl_pkg::BRK_W{1'b0}}, pop_entry.step};
   end

   // Restoring division; the quotient never exceeds ten, so four bits suffice.
   always_comb begin
      den_a          = {{thpl_pkg::STEP_W{1'b0}}, mul_ff.den};
      rem_a          = mul_ff.rem;
      div_in.mv      = mul_ff.mv;
      div_in.den     = mul_ff.den;
      div_in.base    = mul_ff.base;
      div_in.fixed   = mul_ff.fixed;
      div_in.quot_hi = 2'b00;
      if (rem_a >= (den_a << 3)) begin
         rem_a             = rem_a - (den_a << 3);
         div_in.quot_hi[1] = 1'b1;
      end
      if (rem_a >= (den_a << 2)) begin
         rem_a             = rem_a - (den_a << 2);
         div_in.quot_hi[0] = 1'b1;
      end
      div_in.rem = rem_a;
   end

   always_comb begin
      den_b   = {{thpl_pkg::STEP_W{1'b0}}, div_ff.den};
      rem_b   = div_ff.rem;
      quot_lo = 2'b00;
      if (rem_b >= (den_b << 1)) begin
         rem_b      = rem_b - (den_b << 1);
         quot_lo[1] = 1'b1;
      end
      if (rem_b >= den_b) begin
         quot_lo[0] = 1'b1;
      end
      quot        = div_ff.fixed ? '0 : {div_ff.quot_hi, quot_lo};
      rsp_temp_in = div_ff.base + $signed({4'd0, quot});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         div_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= pop_valid;
         div_valid_ff <= mul_valid_ff;
         rsp_valid_ff <= div_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_ff      <= mul_in;
         div_ff      <= div_in;
         rsp_mv_ff   <= div_ff.mv;
         rsp_temp_ff <= rsp_temp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ts_millivolts = rsp_mv_ff;
   assign rsp_temperature_c = rsp_temp_ff;

endmodule

@@ tb/thermistor_piecewise_linear_temp_tb.sv @@
// Testbench for the thermistor reading to temperature converter, with a self-checking scoreboard.
// Drives readings and breakpoint tables through the valid/stall ports and the register port.
// Depends on thpl_pkg and thermistor_piecewise_linear_temp.
module thermistor_piecewise_linear_temp_tb;

   localparam int                     TIMEOUT_TIME     = 4000000;
   localparam int                     SETTLE_CYCLES    = 12;
   localparam int                     LONG_HOLD_CYCLES = 80;
   localparam int                     RANDOM_PHASES    = 8;
   localparam int                     PHASE_READINGS   = 142;
   localparam int                     MV_MAX           = 3276;
   localparam logic [thpl_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = 3'd5;

   typedef enum int {
      TABLE_DESCENDING,
      TABLE_SCRAMBLED,
      TABLE_ALL_HIGH,
      TABLE_ALL_ZERO,
      TABLE_FLAT_STEPS
   } table_kind_type;

   typedef struct packed {
      logic [thpl_pkg::MV_W-1:0]          mv;
      logic signed [thpl_pkg::TEMP_W-1:0] temp;
   } conversion_type;

   class temperature_scoreboard_type;
      bit                      enable;
      thpl_pkg::brk_array_type brk;
      conversion_type          expected_conversions[$];
      int                      errors;
      int                      readings;
      int                      results;
      int                      base_tab[15] = '{-25, -15, -10, -5, 0, 5, 10, 20,
                                                30, 40, 45, 50, 55, 60, 70};
      int                      step_tab[15] = '{10, 5, 5, 5, 5, 5, 10, 10,
                                                10, 5, 5, 5, 5, 10, 10};

      function void write_register(logic [thpl_pkg::CSR_INDEX_W-1:0] idx,
                                   logic [thpl_pkg::CSR_DATA_W-1:0] data);
         if (idx == thpl_pkg::CSR_TEMP_ENABLE) begin
            enable = data[0];
         end else if (idx <= thpl_pkg::CSR_BRK_13_16) begin
            for (int j = 0; j < thpl_pkg::BRK_PER_CSR; j++) begin
               brk[(idx - 1) * thpl_pkg::BRK_PER_CSR + j] =
                  data[thpl_pkg::BRK_W * j +: thpl_pkg::BRK_W];
            end
         end
      endfunction

      function int predict_temperature(int mv);
         int num;
         int den;
         int q;
         if (mv < int'(thpl_pkg::MV_LOW_LIMIT) || !enable) return int'(thpl_pkg::TEMP_DISABLED);
         if (mv < int'(brk[15])) return int'(thpl_pkg::TEMP_HOT);
         for (int k = 15; k >= 1; k--) begin
            if (mv <= int'(brk[k-1])) begin
               num = int'(brk[k-1]) - mv;
               den = int'(brk[k-1]) - int'(brk[k]);
               q   = (den != 0) ? (num * step_tab[k-1]) / den : 0;
               return base_tab[k-1] + q;
            end
         end
         return int'(thpl_pkg::TEMP_COLD);
      endfunction

      function void note_reading(logic [thpl_pkg::RAW_W-1:0] raw);
         conversion_type c;
         int             code;
         code    = int'({raw[15:8], raw[3:0]});
         c.mv    = thpl_pkg::MV_W'((code * 800) / 1000);
         c.temp  = thpl_pkg::TEMP_W'(predict_temperature(int'(c.mv)));
         expected_conversions.push_back(c);
         readings++;
      endfunction

      function void check_result(logic [thpl_pkg::MV_W-1:0] mv,
                                 logic signed [thpl_pkg::TEMP_W-1:0] temp);
         conversion_type c;
         results++;
         if (expected_conversions.size() == 0) begin
            $error("result with nothing outstanding: ts_millivolts %0d temperature_c %0d",
                   mv, temp);
            errors++;
            return;
         end
         c = expected_conversions.pop_front();
         if (mv !== c.mv) begin
            $error("ts_millivolts expected %0d actual %0d", c.mv, mv);
            errors++;
         end
         if (temp !== c.temp) begin
            $error("temperature_c expected %0d actual %0d", c.temp, temp);
            errors++;
         end
      endfunction

      function int pending();
         return expected_conversions.size();
      endfunction
   endclass

   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_valid        = 1'b0;
   logic                                req_stall;
   logic [thpl_pkg::RAW_W-1:0]          req_raw_ts_reading = '0;
   logic                                rsp_valid;
   logic                                rsp_stall        = 1'b0;
   logic [thpl_pkg::MV_W-1:0]           rsp_ts_millivolts;
   logic signed [thpl_pkg::TEMP_W-1:0]  rsp_temperature_c;
   logic                                csr_write_enable = 1'b0;
   logic [thpl_pkg::CSR_INDEX_W-1:0]    csr_index        = '0;
   logic [thpl_pkg::CSR_DATA_W-1:0]     csr_write_data   = '0;

   bit                        hold_pending     = 1'b0;
   bit                        hold_done        = 1'b0;
   int                        hold_left        = 0;
   int                        settings_applied = 0;

   temperature_scoreboard_type sb = new();

   thermistor_piecewise_linear_temp dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_ts_reading (req_raw_ts_reading),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ts_millivolts  (rsp_ts_millivolts),
      .rsp_temperature_c  (rsp_temperature_c),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_ts_millivolts, rsp_temperature_c);
      end
   end

   // The output side switches between stall patterns; a long hold-off is taken once on request.
   initial begin
      int mode;
      int mode_left;
      int cycle;
      mode      = 0;
      mode_left = 0;
      cycle     = 0;
      forever begin
         @(negedge clock);
         cycle++;
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(64, 256);
         end
         mode_left--;
         if (hold_pending && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= cycle[1];
            endcase
         end
      end
   end

   initial begin
      #(TIMEOUT_TIME);
      $display("[thermistor_piecewise_linear_temp] ERROR");
      $finish;
   end

   task automatic write_register(input logic [thpl_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [thpl_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   task automatic apply_settings(input bit en, input thpl_pkg::brk_array_type bp);
      logic [thpl_pkg::CSR_DATA_W-1:0] word;
      word = thpl_pkg::CSR_DATA_W'({$urandom, $urandom});
      word[0] = en;
      write_register(thpl_pkg::CSR_TEMP_ENABLE, word);
      for (int j = 0; j < 4; j++) begin
         word = {bp[4*j+3], bp[4*j+2], bp[4*j+1], bp[4*j]};
         write_register(thpl_pkg::csr_index_type'(thpl_pkg::CSR_BRK_1_4 + j), word);
      end
      write_register(CSR_UNUSED_FIRST + thpl_pkg::CSR_INDEX_W'($urandom_range(0, 2)),
                     thpl_pkg::CSR_DATA_W'({$urandom, $urandom}));
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   task automatic send_reading(input logic [thpl_pkg::RAW_W-1:0] raw);
      @(negedge clock);
      req_valid          <= 1'b1;
      req_raw_ts_reading <= raw;
      do @(posedge clock); while (req_stall);
      sb.note_reading(raw);
   endtask

   task automatic idle_input(input int cycles);
      @(negedge clock);
      req_valid          <= 1'b0;
      req_raw_ts_reading <= thpl_pkg::RAW_W'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic settle();
      idle_input(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [thpl_pkg::RAW_W-1:0] reading_for_mv(input int mv);
      logic [11:0] code;
      logic [3:0]  spare;
      code  = 12'((mv * 5 + 3) / 4);
      spare = 4'($urandom);
      return {code[11:4], spare, code[3:0]};
   endfunction

   function automatic logic [thpl_pkg::RAW_W-1:0] random_reading();
      int pick;
      int mv;
      pick = $urandom_range(0, 9);
      if (pick < 2) return thpl_pkg::RAW_W'($urandom);
      if (pick < 8) begin
         mv = int'(sb.brk[$urandom_range(0, 15)]) + $urandom_range(0, 8) - 4;
      end else if (pick == 8) begin
         mv = $urandom_range(60, 100);
      end else begin
         mv = ($urandom_range(0, 1) == 0) ? 0 : MV_MAX;
      end
      if (mv < 0) mv = 0;
      if (mv > MV_MAX) mv = MV_MAX;
      return reading_for_mv(mv);
   endfunction

   function automatic thpl_pkg::brk_array_type make_table(input table_kind_type kind);
      thpl_pkg::brk_array_type bp;
      int                      b;
      int                      dec;
      b = $urandom_range(2600, 4095);
      for (int k = 0; k < thpl_pkg::BRK_COUNT; k++) begin
         case (kind)
            TABLE_SCRAMBLED: bp[k] = thpl_pkg::BRK_W'($urandom);
            TABLE_ALL_HIGH:  bp[k] = '1;
            TABLE_ALL_ZERO:  bp[k] = '0;
            default: begin
               bp[k] = thpl_pkg::BRK_W'(b);
               if (kind == TABLE_FLAT_STEPS && $urandom_range(0, 1) == 0) begin
                  dec = 0;
               end else begin
                  dec = $urandom_range(1, (kind == TABLE_FLAT_STEPS) ? 400 : 260);
               end
               b = (b > dec) ? b - dec : 0;
            end
         endcase
      end
      if (kind == TABLE_FLAT_STEPS) bp[15] = bp[14];
      return bp;
   endfunction

   task automatic run_readings(input int count, input bit with_gaps);
      int burst;
      burst = $urandom_range(1, 24);
      for (int i = 0; i < count; i++) begin
         send_reading(random_reading());
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            if (with_gaps) idle_input($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      thpl_pkg::brk_array_type bp;
      table_kind_type          kind;
      bit                      en;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers at their reset values: everything reads as disabled.
      send_reading('0);
      send_reading('1);
      send_reading(16'h00F0);
      settle();

      // A fixed descending table, probing the limits of each rule.
      for (int k = 0; k < thpl_pkg::BRK_COUNT; k++) bp[k] = thpl_pkg::BRK_W'(3100 - 180 * k);
      apply_settings(1'b1, bp);
      send_reading(reading_for_mv(0));
      send_reading(reading_for_mv(79));
      send_reading(reading_for_mv(80));
      send_reading(reading_for_mv(int'(bp[15]) - 1));
      send_reading(reading_for_mv(int'(bp[15])));
      send_reading(reading_for_mv(int'(bp[0])));
      send_reading(reading_for_mv(int'(bp[0]) + 1));
      send_reading(reading_for_mv(MV_MAX));
      for (int k = 0; k < 15; k += 2) begin
         send_reading(reading_for_mv(int'(bp[k]) - 90));
      end
      send_reading('1);
      settle();

      // The last two breakpoints equal, so the final segment has no width.
      for (int k = 0; k < thpl_pkg::BRK_COUNT; k++) bp[k] = thpl_pkg::BRK_W'(2500 - 100 * k);
      bp[15] = bp[14];
      apply_settings(1'b1, bp);
      send_reading(reading_for_mv(int'(bp[15])));
      send_reading(reading_for_mv(int'(bp[15]) - 1));
      send_reading(reading_for_mv(int'(bp[15]) + 1));
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         kind = (p < 5) ? table_kind_type'(p) : table_kind_type'($urandom_range(0, 4));
         en   = (p == 5) ? 1'b0 : ($urandom_range(0, 7) != 0);
         apply_settings(en, make_table(kind));
         if (p == 2) hold_pending = 1'b1;
         run_readings(PHASE_READINGS, (p != 2) && (p != 6));
         settle();
      end

      $display("Checked %0d results from %0d readings across %0d table settings,",
               sb.results, sb.readings, settings_applied);
      $display("including flat and scrambled tables, disabled conversion and a long output hold-off.");
      if (sb.errors == 0) begin
         $display("[thermistor_piecewise_linear_temp] OK");
      end else begin
         $display("[thermistor_piecewise_linear_temp] ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/thpl_pkg.sv
design/thpl_front.sv
design/thpl_queue.sv
design/thpl_back.sv
design/thermistor_piecewise_linear_temp.sv
tb/thermistor_piecewise_linear_temp_tb.sv
